FILE: rtl/crcp_pkg.sv
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared constants, types and helper functions of the CRC peripheral.
// ----------------------------------------------------------------------------
`default_nettype none

package crcp_pkg;

   localparam logic [31:0] CRC_RESET   = 32'hFFFF_FFFF;
   localparam logic [31:0] POLY_RESET  = 32'h0000_1021;
   localparam logic [31:0] CTRL_RESET  = 32'h0000_0000;
   localparam logic [31:0] CTRL_KEEP   = 32'hF700_0000;
   localparam logic [4:0]  WINDOW_SIZE = 5'd12;

   // control bit positions
   localparam int CTRL_TCRC = 24;
   localparam int CTRL_WAS  = 25;
   localparam int CTRL_FXOR = 26;

   // bus operation
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // register select, offset[3:2]
   localparam logic [1:0] REG_DATA = 2'd0;
   localparam logic [1:0] REG_POLY = 2'd1;
   localparam logic [1:0] REG_CTRL = 2'd2;

   // transpose codes
   localparam logic [1:0] TR_NONE      = 2'd0;
   localparam logic [1:0] TR_BITS      = 2'd1;
   localparam logic [1:0] TR_BITS_BYTE = 2'd2;
   localparam logic [1:0] TR_BYTES     = 2'd3;

   typedef struct packed {
      logic we;
      logic last;
   } crcp_feed_type;

   function automatic logic [7:0] crcp_rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   function automatic logic [31:0] crcp_lane_mask(input logic [2:0] size);
      logic [31:0] m;
      case (size)
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] crcp_merge(input logic [31:0] old_val,
                                              input logic [31:0] val,
                                              input logic [1:0]  lane,
                                              input logic [2:0]  size);
      logic [31:0] m;
      m = crcp_lane_mask(size) << {lane, 3'b000};
      return (old_val & ~m) | ((val << {lane, 3'b000}) & m);
   endfunction

   // CRC value as seen on a data read
   function automatic logic [31:0] crcp_view(input logic [31:0] crc,
                                             input logic [31:0] ctrl);
      logic [31:0] res;
      logic [1:0]  tr;
      logic        wide;
      tr   = ctrl[29:28];
      wide = ctrl[CTRL_TCRC];
      res  = crc;
      if (wide) begin
         unique case (tr)
            TR_NONE:      res = crc;
            TR_BITS:      res = {crcp_rev8(crc[31:24]), crcp_rev8(crc[23:16]),
                                 crcp_rev8(crc[15:8]),  crcp_rev8(crc[7:0])};
            TR_BITS_BYTE: res = {crcp_rev8(crc[7:0]),   crcp_rev8(crc[15:8]),
                                 crcp_rev8(crc[23:16]), crcp_rev8(crc[31:24])};
            TR_BYTES:     res = {crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
            default:      res = crc;
         endcase
      end else begin
         unique case (tr)
            TR_NONE:      res[15:0] = crc[15:0];
            TR_BITS:      res[15:0] = {crcp_rev8(crc[15:8]), crcp_rev8(crc[7:0])};
            TR_BITS_BYTE: res[15:0] = {crcp_rev8(crc[7:0]), crcp_rev8(crc[15:8])};
            TR_BYTES:     res[15:0] = {crc[7:0], crc[15:8]};
            default:      res[15:0] = crc[15:0];
         endcase
      end
      if (ctrl[CTRL_FXOR]) begin
         res = ~res;
      end
      return wide ? res : {crc[31:16], res[15:0]};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/crcp_engine.sv
// ----------------------------------------------------------------------------
// crcp_engine
// Byte-serial CRC feeder: shifts the written word out one byte per cycle,
// applies the write transpose and advances the CRC by one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crcp_engine
   import crcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] data,
   input  wire logic [2:0]  size,
   input  wire logic [1:0]  tw,
   input  wire logic        wide,
   input  wire logic [31:0] crc_in,
   input  wire logic [31:0] poly,
   output      logic [31:0] crc_out,
   output      crcp_feed_type feed
);

   logic [31:0] sr_ff, sr_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [7:0]  byte_raw, byte_fed;
   logic        rev_order, rev_bits;

   assign rev_order = tw[1];
   assign rev_bits  = (tw == TR_BITS) || (tw == TR_BITS_BYTE);
   assign byte_raw  = rev_order ? sr_ff[31:24] : sr_ff[7:0];
   assign byte_fed  = rev_bits ? crcp_rev8(byte_raw) : byte_raw;

   always_comb begin
      logic [31:0] c;
      logic [31:0] mask;
      logic        top;
      mask = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
      c    = crc_in & mask;
      c    = c ^ (wide ? {byte_fed, 24'd0} : {16'd0, byte_fed, 8'd0});
      for (int i = 0; i < 8; i++) begin
         top = wide ? c[31] : c[15];
         c   = (c << 1) & mask;
         if (top) begin
            c = c ^ (poly & mask);
         end
      end
      crc_out = c;
   end

   assign feed.we   = busy_ff;
   assign feed.last = busy_ff && (cnt_ff == 3'd1);

   always_comb begin
      sr_in   = sr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = size;
         if (rev_order) begin
            case (size)
               3'd1:    sr_in = data << 24;
               3'd2:    sr_in = data << 16;
               default: sr_in = data;
            endcase
         end else begin
            sr_in = data;
         end
      end else if (busy_ff) begin
         sr_in  = rev_order ? (sr_ff << 8) : (sr_ff >> 8);
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sr_ff <= sr_in;
   end

endmodule

`default_nettype wire

FILE: rtl/configurable_crc_peripheral_unit.sv
// ----------------------------------------------------------------------------
// configurable_crc_peripheral_unit
// Programmable 16/32-bit CRC behind a 12-byte register window.
// ----------------------------------------------------------------------------
// One bus access per request word. A read, a polynomial or control write, a
// seed write or a rejected access goes from EXEC through RESP to the output
// register; a CRC data write also passes FEED, where the CRC advances one byte
// per cycle, up to 4 bytes, through a single byte-wide polynomial step. A new
// request is taken once the previous response has been loaded into the output
// register, even if that response is still stalled.
`default_nettype none

module configurable_crc_peripheral_unit
   import crcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_op,
   input  wire logic [3:0]  req_offset,
   input  wire logic [2:0]  req_size_bytes,
   input  wire logic [31:0] req_write_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_read_data,
   output      logic        rsp_access_ok
);

   typedef enum logic [1:0] {IDLE, EXEC, FEED, RESP} state_type;

   state_type   state_ff, state_in;
   logic        op_ff, op_in;
   logic [3:0]  off_ff, off_in;
   logic [2:0]  size_ff, size_in;
   logic [31:0] wd_ff, wd_in;
   logic [31:0] res_ff, res_in;
   logic        ok_ff, ok_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] poly_ff, poly_in;
   logic [31:0] ctrl_ff, ctrl_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_access_ok_ff, rsp_access_ok_in;

   logic          acc_ok;
   logic [1:0]    lane;
   logic [1:0]    region;
   logic [31:0]   read_val;
   logic          feed_start;
   logic [31:0]   feed_crc;
   crcp_feed_type feed;

   assign lane   = off_ff[1:0];
   assign region = off_ff[3:2];
   assign acc_ok = ((size_ff == 3'd1) || (size_ff == 3'd2) || (size_ff == 3'd4)) &&
                   ((off_ff & ({1'b0, size_ff} - 4'd1)) == 4'd0) &&
                   (({1'b0, off_ff} + {2'b00, size_ff}) <= WINDOW_SIZE);

   always_comb begin
      unique case (region)
         REG_DATA: read_val = (crcp_view(crc_ff, ctrl_ff) >> {lane, 3'b000}) &
                              crcp_lane_mask(size_ff);
         REG_POLY: read_val = poly_ff >> {lane, 3'b000};
         REG_CTRL: read_val = ctrl_ff >> {lane, 3'b000};
         default:  read_val = 32'd0;
      endcase
   end

   assign feed_start = (state_ff == EXEC) && acc_ok && (op_ff == OP_WRITE) &&
                       (region == REG_DATA) && !ctrl_ff[CTRL_WAS];

   crcp_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (feed_start),
      .data    (wd_ff),
      .size    (size_ff),
      .tw      (ctrl_ff[31:30]),
      .wide    (ctrl_ff[CTRL_TCRC]),
      .crc_in  (crc_ff),
      .poly    (poly_ff),
      .crc_out (feed_crc),
      .feed    (feed)
   );

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      off_in           = off_ff;
      size_in          = size_ff;
      wd_in            = wd_ff;
      res_in           = res_ff;
      ok_in            = ok_ff;
      crc_in           = crc_ff;
      poly_in          = poly_ff;
      ctrl_in          = ctrl_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_access_ok_in = rsp_access_ok_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               off_in   = req_offset;
               size_in  = req_size_bytes;
               wd_in    = req_write_data;
               state_in = EXEC;
            end
         end
         EXEC: begin
            ok_in    = acc_ok;
            res_in   = 32'd0;
            state_in = RESP;
            if (acc_ok) begin
               if (op_ff == OP_READ) begin
                  res_in = read_val;
               end else begin
                  unique case (region)
                     REG_DATA: begin
                        if (ctrl_ff[CTRL_WAS]) begin
                           crc_in = crcp_merge(crc_ff, wd_ff, lane, size_ff);
                        end else begin
                           state_in = FEED;
                        end
                     end
                     REG_POLY: poly_in = crcp_merge(poly_ff, wd_ff, lane, size_ff);
                     REG_CTRL: ctrl_in = crcp_merge(ctrl_ff, wd_ff, lane, size_ff) &
                                         CTRL_KEEP;
                     default: ;
                  endcase
               end
            end
         end
         FEED: begin
            if (feed.we) begin
               crc_in = feed_crc;
            end
            if (feed.last) begin
               state_in = RESP;
            end
         end
         RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = res_ff;
               rsp_access_ok_in = ok_ff;
               state_in         = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_RESET;
         poly_ff      <= POLY_RESET;
         ctrl_ff      <= CTRL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         poly_ff      <= poly_in;
         ctrl_ff      <= ctrl_in;
      end
      op_ff            <= op_in;
      off_ff           <= off_in;
      size_ff          <= size_in;
      wd_ff            <= wd_in;
      res_ff           <= res_in;
      ok_ff            <= ok_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_access_ok_ff <= rsp_access_ok_in;
   end

   assign req_stall     = (state_ff != IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_access_ok = rsp_access_ok_ff;

endmodule

`default_nettype wire

FILE: rtl/crcp_checker.sv
// ----------------------------------------------------------------------------
// crcp_checker
// Port-level checks of the CRC peripheral, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crcp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_read_data,
   input wire logic        rsp_access_ok
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
                                 $stable(rsp_access_ok))
      else $error("stalled response word changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_access_ok |-> rsp_read_data == 32'd0)
      else $error("rejected access returned nonzero data");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word in flight");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind configurable_crc_peripheral_unit crcp_checker u_crcp_checker (.*);

`default_nettype wire

FILE: tb/tb_configurable_crc_peripheral_unit.sv
// ----------------------------------------------------------------------------
// tb_configurable_crc_peripheral_unit
// Self-checking bench for the programmable CRC peripheral. A short table of
// bus accesses covers reset values, rejected accesses, lane shifts, seed mode,
// the transposes and both CRC widths. Random accesses follow, mostly
// well-formed register traffic with some garbage. Each access is predicted by
// a behavioral model of the register window and the response word is compared
// field by field. Sender and receiver back-pressure vary by phase.
// ----------------------------------------------------------------------------
module tb_configurable_crc_peripheral_unit
   import crcp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        op;
      logic [3:0]  offset;
      logic [2:0]  size;
      logic [31:0] wdata;
      logic        fixed;
      logic [31:0] rd;
      logic        ok;
   } bus_vector_type;

   typedef struct packed {
      logic [31:0] rd;
      logic        ok;
   } bus_response_type;

   localparam int DIR_ROWS    = 27;
   localparam int RAND_PHASE  = 284;
   localparam int TAIL_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [3:0]  req_offset;
   logic [2:0]  req_size_bytes;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_access_ok;

   logic        req_fixed;
   logic [31:0] req_fixed_rd;
   logic        req_fixed_ok;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int check_errors  = 0;

   logic [31:0] crc_val;
   logic [31:0] poly_val;
   logic [31:0] ctrl_val;

   bus_response_type response_q[$];
   bus_vector_type   dir_tab [DIR_ROWS];

   configurable_crc_peripheral_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_offset     (req_offset),
      .req_size_bytes (req_size_bytes),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_access_ok  (rsp_access_ok)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // ---- register window model ----

   function automatic logic [7:0] flip_byte(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return r;
   endfunction

   function automatic logic [31:0] size_mask(input logic [2:0] size);
      return (size == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * size)) - 32'd1);
   endfunction

   function automatic logic [31:0] overlay_lanes(input logic [31:0] old_word,
                                                 input logic [31:0] new_word,
                                                 input int          shift,
                                                 input logic [2:0]  size);
      logic [31:0] m;
      m = size_mask(size) << shift;
      return (old_word & ~m) | ((new_word << shift) & m);
   endfunction

   function automatic void crc_feed_byte(input logic [7:0] b);
      logic [31:0] c;
      logic [31:0] mask;
      logic        msb;
      int          top;
      if (ctrl_val[CTRL_TCRC]) begin
         mask = 32'hFFFF_FFFF;
         top  = 31;
      end else begin
         mask = 32'h0000_FFFF;
         top  = 15;
      end
      c = (crc_val & mask) ^ ({24'd0, b} << (top - 7));
      for (int i = 0; i < 8; i++) begin
         msb = c[top];
         c   = (c << 1) & mask;
         if (msb) begin
            c = c ^ (poly_val & mask);
         end
      end
      crc_val = c;
   endfunction

   function automatic logic [31:0] crc_readback();
      logic [31:0] res;
      logic [7:0]  b;
      logic [1:0]  tr;
      int          nb;
      int          dst;
      nb  = ctrl_val[CTRL_TCRC] ? 4 : 2;
      tr  = ctrl_val[29:28];
      res = '0;
      for (int i = 0; i < nb; i++) begin
         b   = crc_val[i*8 +: 8];
         dst = (tr == TR_BITS_BYTE || tr == TR_BYTES) ? nb - 1 - i : i;
         if (tr == TR_BITS || tr == TR_BITS_BYTE) begin
            b = flip_byte(b);
         end
         res[dst*8 +: 8] = b;
      end
      if (ctrl_val[CTRL_FXOR]) begin
         res = ~res;
      end
      return ctrl_val[CTRL_TCRC] ? res : {crc_val[31:16], res[15:0]};
   endfunction

   function automatic void predict_access(input  logic        op,
                                          input  logic [3:0]  off,
                                          input  logic [2:0]  size,
                                          input  logic [31:0] wd,
                                          output logic [31:0] rd,
                                          output logic        ok);
      logic [1:0] sel;
      logic [1:0] tw;
      logic [7:0] b;
      int         o;
      int         s;
      int         sh;
      int         src;
      rd = '0;
      ok = 1'b0;
      o  = off;
      s  = size;
      if (!(s == 1 || s == 2 || s == 4)) begin
         return;
      end
      if ((o % s) != 0 || o + s > WINDOW_SIZE) begin
         return;
      end
      ok  = 1'b1;
      sel = off[3:2];
      sh  = 8 * off[1:0];
      if (op == OP_READ) begin
         case (sel)
            REG_DATA: rd = (crc_readback() >> sh) & size_mask(size);
            REG_POLY: rd = poly_val >> sh;
            default:  rd = ctrl_val >> sh;
         endcase
      end else begin
         case (sel)
            REG_DATA: begin
               if (ctrl_val[CTRL_WAS]) begin
                  crc_val = overlay_lanes(crc_val, wd, sh, size);
               end else begin
                  tw = ctrl_val[31:30];
                  for (int i = 0; i < s; i++) begin
                     src = (tw == TR_BITS_BYTE || tw == TR_BYTES) ? s - 1 - i : i;
                     b   = wd[src*8 +: 8];
                     if (tw == TR_BITS || tw == TR_BITS_BYTE) begin
                        b = flip_byte(b);
                     end
                     crc_feed_byte(b);
                  end
               end
            end
            REG_POLY: poly_val = overlay_lanes(poly_val, wd, sh, size);
            default:  ctrl_val = overlay_lanes(ctrl_val, wd, sh, size) & CTRL_KEEP;
         endcase
      end
   endfunction

   // ---- acceptance and checking ----

   always @(posedge clock) begin
      logic [31:0]      p_rd;
      logic             p_ok;
      bus_response_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_access(req_op, req_offset, req_size_bytes, req_write_data, p_rd, p_ok);
            if (req_fixed) begin
               p_rd = req_fixed_rd;
               p_ok = req_fixed_ok;
            end
            response_q.push_back(bus_response_type'{rd: p_rd, ok: p_ok});
         end
         if (rsp_valid && !rsp_stall) begin
            if (response_q.size() == 0) begin
               check_errors++;
               $display("%0t: unexpected response word rd=%h ok=%b",
                        $time, rsp_read_data, rsp_access_ok);
            end else begin
               want = response_q.pop_front();
               if (rsp_read_data !== want.rd) begin
                  check_errors++;
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.rd, rsp_read_data);
               end
               if (rsp_access_ok !== want.ok) begin
                  check_errors++;
                  $display("%0t: access_ok expected %b actual %b",
                           $time, want.ok, rsp_access_ok);
               end
            end
         end
      end
   end

   // ---- stimulus ----

   task automatic send_word(input logic        op,
                            input logic [3:0]  off,
                            input logic [2:0]  size,
                            input logic [31:0] wd,
                            input logic        fixed,
                            input logic [31:0] fixed_rd,
                            input logic        fixed_ok);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      while (gap > 0) begin
         req_valid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_offset     <= off;
      req_size_bytes <= size;
      req_write_data <= wd;
      req_fixed      <= fixed;
      req_fixed_rd   <= fixed_rd;
      req_fixed_ok   <= fixed_ok;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic make_random_access(output logic        op,
                                     output logic [3:0]  off,
                                     output logic [2:0]  size,
                                     output logic [31:0] wd);
      int         pick;
      logic [1:0] sel;
      pick = $urandom_range(0, 99);
      wd   = $urandom();
      op   = OP_WRITE;
      sel  = REG_DATA;
      size = 3'(1 << $urandom_range(0, 2));
      if (pick < 8) begin
         // garbage: any op, offset and size
         op   = 1'($urandom());
         off  = 4'($urandom());
         size = 3'($urandom());
      end else begin
         if (pick < 16) begin
            sel = REG_CTRL;
            if ($urandom_range(0, 3) != 0) begin
               wd[CTRL_WAS] = 1'b0;
            end
         end else if (pick < 21) begin
            sel = REG_POLY;
         end else if (pick >= 70) begin
            op  = OP_READ;
            sel = 2'($urandom_range(0, 2));
         end
         off = 4'(4 * sel + size * $urandom_range(0, 4 / size - 1));
      end
   endtask

   initial begin
      logic        r_op;
      logic [3:0]  r_off;
      logic [2:0]  r_size;
      logic [31:0] r_wd;
      int          guard;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_READ;
      req_offset     = '0;
      req_size_bytes = '0;
      req_write_data = '0;
      req_fixed      = 1'b0;
      req_fixed_rd   = '0;
      req_fixed_ok   = 1'b0;
      crc_val        = 32'hFFFF_FFFF;
      poly_val       = 32'h0000_1021;
      ctrl_val       = 32'h0000_0000;

      dir_tab = '{
         '{OP_READ,  4'd0,  3'd4, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
         '{OP_READ,  4'd4,  3'd4, 32'h0000_0000, 1'b1, 32'h0000_1021, 1'b1},
         '{OP_READ,  4'd8,  3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
         '{OP_READ,  4'd1,  3'd2, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd12, 3'd1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd15, 3'd4, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd0,  3'd3, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd0,  3'd7, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd8,  3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd10, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd8,  3'd4, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd11, 3'd1, 32'h0000_0000, 1'b1, 32'h0000_00F7, 1'b1},
         '{OP_READ,  4'd10, 3'd2, 32'h0000_0000, 1'b1, 32'h0000_F700, 1'b1},
         '{OP_WRITE, 4'd4,  3'd4, 32'h04C1_1DB7, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd5,  3'd1, 32'h0000_0000, 1'b1, 32'h0004_C11D, 1'b1},
         // 32-bit, seed mode
         '{OP_WRITE, 4'd8,  3'd4, 32'h0300_0000, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd0,  3'd4, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd1,  3'd1, 32'h0000_00AB, 1'b0, 32'h0000_0000, 1'b0},
         // 32-bit, bit-reversed feed, full reversed readback, complemented
         '{OP_WRITE, 4'd8,  3'd4, 32'h6500_0000, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd0,  3'd4, 32'h3132_3334, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd2,  3'd2, 32'h0000_FFFF, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd0,  3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd3,  3'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
         // 16-bit, byte swaps both ways; feeding clears the upper half
         '{OP_WRITE, 4'd8,  3'd4, 32'hF000_0000, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd4,  3'd2, 32'h0000_8005, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_WRITE, 4'd0,  3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
         '{OP_READ,  4'd0,  3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 45;
      foreach (dir_tab[i]) begin
         send_word(dir_tab[i].op, dir_tab[i].offset, dir_tab[i].size, dir_tab[i].wdata,
                   dir_tab[i].fixed, dir_tab[i].rd, dir_tab[i].ok);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 29 : 0;
         for (int n = 0; n < RAND_PHASE; n++) begin
            if (phase == 1 && n == RAND_PHASE / 2) begin
               // hold off until the pipe is empty
               @(negedge clock);
               req_valid <= 1'b0;
               while (response_q.size() != 0) @(negedge clock);
            end
            make_random_access(r_op, r_off, r_size, r_wd);
            send_word(r_op, r_off, r_size, r_wd, 1'b0, 32'h0, 1'b0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (response_q.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (response_q.size() != 0) begin
         check_errors++;
         $display("%0t: %0d response words never arrived", $time, response_q.size());
      end
      if (check_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/crcp_pkg.sv
rtl/crcp_engine.sv
rtl/configurable_crc_peripheral_unit.sv
rtl/crcp_checker.sv
tb/tb_configurable_crc_peripheral_unit.sv
